### hdl/grouped_int4_matvec_row_assert.svh
// assertion macros shared by the RTL
`ifndef GROUPED_INT4_MATVEC_ROW_ASSERT_SVH
`define GROUPED_INT4_MATVEC_ROW_ASSERT_SVH

// same-cycle implication, checked outside reset
`define GIMV_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("grouped_int4_matvec_row: assertion failed");

// next-cycle implication, checked outside reset
`define GIMV_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("grouped_int4_matvec_row: assertion failed");

`endif

### hdl/gimv_pkg.sv
package gimv_pkg;

  localparam int MaxRowsDef   = 256;
  localparam int MaxColsDef   = 1024;
  localparam int MaxGroupsDef = 64;

  typedef enum logic [1:0] {
    OP_LOAD_W   = 2'd0,
    OP_LOAD_S   = 2'd1,
    OP_LOAD_ACT = 2'd2,
    OP_RUN      = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    CFG_ROWS = 2'd0,
    CFG_COLS = 2'd1,
    CFG_GS   = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    FPU_MUL = 1'b0,
    FPU_ADD = 1'b1
  } fpu_op_e;

  localparam logic [31:0] FpDefaultNan = 32'hFFC0_0000;
  localparam logic [31:0] FpQuietBit   = 32'h0040_0000;

endpackage

### hdl/gimv_fpu.sv
module gimv_fpu
  import gimv_pkg::*;
(
  input  fpu_op_e     op_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic [31:0] res_o
);

  function automatic logic [31:0] rnd_pack(input logic s, input logic signed [11:0] e,
                                           input logic [26:0] sig);
    logic [26:0] sg;
    logic [11:0] sh;
    logic [26:0] mask;
    logic        inc;
    logic [30:0] pk;
    logic [7:0]  ef;
    sg = sig;
    ef = e[7:0];
    sh = 12'd0;
    mask = 27'd0;
    if (e >= 12'sd255) return {s, 8'hFF, 23'd0};
    if (e <= 12'sd0) begin
      sh = 12'd1 - e;
      if (sh >= 12'd27) begin
        sg = {26'd0, |sig};
      end else begin
        mask = (27'd1 << sh[4:0]) - 27'd1;
        sg = (sig >> sh[4:0]) | {26'd0, |(sig & mask)};
      end
      ef = 8'd0;
    end
    inc = sg[2] & (sg[1] | sg[0] | sg[3]);
    pk = {ef, sg[25:3]} + {30'd0, inc};
    return {s, pk};
  endfunction

  function automatic logic [31:0] fmul(input logic [31:0] a, input logic [31:0] b);
    logic        s;
    logic [7:0]  ea, eb;
    logic [23:0] ma, mb;
    logic [47:0] p, pn;
    logic [5:0]  lz;
    logic [11:0] e;
    logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
    s = a[31] ^ b[31];
    a_nan = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
    b_nan = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
    a_inf = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
    b_inf = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
    a_zero = (a[30:0] == 31'd0);
    b_zero = (b[30:0] == 31'd0);
    ea = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
    eb = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
    ma = {|a[30:23], a[22:0]};
    mb = {|b[30:23], b[22:0]};
    p = ma * mb;
    lz = 6'd0;
    for (int i = 0; i < 48; i++) begin
      if (p[i]) lz = 6'(47 - i);
    end
    pn = p << lz;
    e = 12'(ea) + 12'(eb) - 12'd126 - 12'(lz);
    if (a_nan) return a | FpQuietBit;
    if (b_nan) return b | FpQuietBit;
    if ((a_inf && b_zero) || (b_inf && a_zero)) return FpDefaultNan;
    if (a_inf || b_inf) return {s, 8'hFF, 23'd0};
    if (p == 48'd0) return {s, 31'd0};
    return rnd_pack(s, e, {pn[47:22], |pn[21:0]});
  endfunction

  function automatic logic [31:0] fadd(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] x, y;
    logic [7:0]  ex, ey, d;
    logic [26:0] mx, my0, my, mask;
    logic [27:0] s28;
    logic [26:0] sig;
    logic [4:0]  lz;
    logic [11:0] e;
    logic        a_nan, b_nan, a_inf, b_inf;
    a_nan = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
    b_nan = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
    a_inf = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
    b_inf = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
    if (b[30:0] > a[30:0]) begin
      x = b;
      y = a;
    end else begin
      x = a;
      y = b;
    end
    ex = (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
    ey = (y[30:23] == 8'd0) ? 8'd1 : y[30:23];
    d = ex - ey;
    mx = {|x[30:23], x[22:0], 3'd0};
    my0 = {|y[30:23], y[22:0], 3'd0};
    mask = 27'd0;
    if (d >= 8'd27) begin
      my = {26'd0, |my0};
    end else begin
      mask = (27'd1 << d[4:0]) - 27'd1;
      my = (my0 >> d[4:0]) | {26'd0, |(my0 & mask)};
    end
    if (x[31] == y[31]) s28 = {1'b0, mx} + {1'b0, my};
    else s28 = {1'b0, mx} - {1'b0, my};
    lz = 5'd0;
    for (int i = 0; i < 27; i++) begin
      if (s28[i]) lz = 5'(26 - i);
    end
    if (s28[27]) begin
      sig = {s28[27:2], s28[1] | s28[0]};
      e = 12'(ex) + 12'd1;
    end else begin
      sig = s28[26:0] << lz;
      e = 12'(ex) - 12'(lz);
    end
    if (a_nan) return a | FpQuietBit;
    if (b_nan) return b | FpQuietBit;
    if (a_inf && b_inf && (a[31] != b[31])) return FpDefaultNan;
    if (a_inf) return a;
    if (b_inf) return b;
    if (s28 == 28'd0) return {a[31] & b[31], 31'd0};
    return rnd_pack(x[31], e, sig);
  endfunction

  always_comb begin
    res_o = (op_i == FPU_ADD) ? fadd(a_i, b_i) : fmul(a_i, b_i);
  end

endmodule

### hdl/grouped_int4_matvec_row.sv
// a run enters, then for each group sets up, reads and accumulates the group columns,
// drains the read pipeline, scales the group sum and adds it, and ends with the final scale
// loads are written as they are accepted; one transaction is in flight at a time
// throughput is set by the single read ports of the weight and activation stores (one column
// per cycle) and by the one shared fp32 multiply/add unit
// reset clears the sequencer, output valid and config registers; stores are not cleared
`include "grouped_int4_matvec_row_assert.svh"

module grouped_int4_matvec_row
  import gimv_pkg::*;
#(
  parameter int MAX_ROWS   = MaxRowsDef,
  parameter int MAX_COLS   = MaxColsDef,
  parameter int MAX_GROUPS = MaxGroupsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // input channel
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        operation_i,
  input  logic [7:0]        row_index_i,
  input  logic [9:0]        column_index_i,
  input  logic [7:0]        weight_byte_i,
  input  logic [15:0]       group_scale_half_i,
  input  logic signed [7:0] activation_value_i,
  input  logic [31:0]       activation_scale_i,
  // output channel
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [7:0]        result_row_o,
  output logic [31:0]       result_bits_o,
  // config write port
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_index_i,
  input  logic [10:0]       cfg_data_i
);

  // derived sizes
  localparam int WB   = (MAX_COLS + 1) / 2;              // weight bytes per row
  localparam int WAW  = $clog2(MAX_ROWS * WB);
  localparam int SAW  = $clog2(MAX_ROWS * MAX_GROUPS);
  localparam int AAW  = $clog2(MAX_COLS);
  localparam int RW   = $clog2(MAX_ROWS + 1);
  localparam int CW   = $clog2(MAX_COLS + 1);
  localparam int CW2  = CW + 1;                          // holds a group end before clipping
  localparam int GW   = $clog2(MAX_GROUPS + 1);
  localparam int DW   = $clog2(MAX_COLS) + 13;           // exact int dot product
  localparam int ROWS_RST = (MAX_ROWS < 256) ? MAX_ROWS : 256;
  localparam int COLS_RST = (MAX_COLS < 1024) ? MAX_COLS : 1024;
  localparam int GS_RST   = (MAX_COLS < 32) ? MAX_COLS : 32;

  // sequencer states
  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_GRP   = 7'b0000010,
    S_DOT   = 7'b0000100,
    S_DRAIN = 7'b0001000,
    S_MUL   = 7'b0010000,
    S_ADD   = 7'b0100000,
    S_FIN   = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  // config registers, saturated on write
  logic [RW-1:0] rows_q, rows_d;
  logic [CW-1:0] cols_q, cols_d;
  logic [CW-1:0] gs_q, gs_d;
  int rv, cv, gv;

  always_comb begin
    rv = int'(cfg_data_i[8:0]);
    cv = int'(cfg_data_i);
    gv = int'(cfg_data_i);
    if (rv < 1) rv = 1;
    if (rv > MAX_ROWS) rv = MAX_ROWS;
    if (cv < 1) cv = 1;
    if (cv > MAX_COLS) cv = MAX_COLS;
    if (gv < 16) gv = 16;
    if (gv > MAX_COLS) gv = MAX_COLS;
    rows_d = rows_q;
    cols_d = cols_q;
    gs_d   = gs_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_ROWS: rows_d = RW'(rv);
        CFG_COLS: cols_d = CW'(cv);
        CFG_GS:   gs_d   = CW'(gv);
        default:  ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= RW'(ROWS_RST);
      cols_q <= CW'(COLS_RST);
      gs_q   <= CW'(GS_RST);
    end else begin
      rows_q <= rows_d;
      cols_q <= cols_d;
      gs_q   <= gs_d;
    end
  end

  // input transaction decode
  logic in_acc;
  logic ld_w, ld_s, ld_a, run_ok;
  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;

  always_comb begin
    ld_w   = 1'b0;
    ld_s   = 1'b0;
    ld_a   = 1'b0;
    run_ok = 1'b0;
    unique case (op_e'(operation_i))
      OP_LOAD_W:   ld_w = (int'(row_index_i) < MAX_ROWS) &&
                          (2 * int'(column_index_i) < MAX_COLS);
      OP_LOAD_S:   ld_s = (int'(row_index_i) < MAX_ROWS) &&
                          (int'(column_index_i) < MAX_GROUPS);
      OP_LOAD_ACT: ld_a = (int'(column_index_i) < MAX_COLS);
      OP_RUN:      run_ok = (int'(row_index_i) < int'(rows_q));
      default:     ;
    endcase
  end

  // run context
  logic [7:0]     run_row_q;
  logic [31:0]    ascale_q;
  logic [CW2-1:0] gstart_q, gend_q, col_q;
  logic [GW-1:0]  g_q;
  logic [CW2-1:0] gsum, gend_new;

  assign gsum     = gstart_q + CW2'(gs_q);
  assign gend_new = (gsum > CW2'(cols_q)) ? CW2'(cols_q) : gsum;

  // stores: weight bytes, group scales, activations
  logic [7:0]  wmem [MAX_ROWS*WB];
  logic [15:0] smem [MAX_ROWS*MAX_GROUPS];
  logic [7:0]  amem [MAX_COLS];
  logic [7:0]  w_rd_q, a_rd_q;
  logic [15:0] s_rd_q;
  logic [WAW-1:0] w_waddr, w_raddr;
  logic [SAW-1:0] s_waddr, s_raddr;

  assign w_waddr = WAW'(int'(row_index_i) * WB + int'(column_index_i));
  assign w_raddr = WAW'(int'(run_row_q) * WB + int'(col_q >> 1));
  assign s_waddr = SAW'(int'(row_index_i) * MAX_GROUPS + int'(column_index_i));
  assign s_raddr = SAW'(int'(run_row_q) * MAX_GROUPS + int'(g_q));

  always_ff @(posedge clk_i) begin
    if (in_acc && ld_w) wmem[w_waddr] <= weight_byte_i;
    w_rd_q <= wmem[w_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && ld_s) smem[s_waddr] <= group_scale_half_i;
    s_rd_q <= smem[s_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && ld_a) amem[column_index_i[AAW-1:0]] <= activation_value_i;
    a_rd_q <= amem[col_q[AAW-1:0]];
  end

  // integer multiply-accumulate, one column per cycle behind the read port
  logic                 pipe_vld_q, sel_q;
  logic [3:0]           nib;
  logic signed [4:0]    wval;
  logic signed [12:0]   mac_p;
  logic signed [DW-1:0] dot_q, dot_d;

  assign nib   = sel_q ? w_rd_q[7:4] : w_rd_q[3:0];
  assign wval  = $signed({1'b0, nib}) - 5'sd8;
  assign mac_p = wval * $signed(a_rd_q);

  always_comb begin
    dot_d = dot_q;
    if (state_q == S_GRP) dot_d = '0;
    else if (pipe_vld_q) dot_d = dot_q + DW'(mac_p);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pipe_vld_q <= 1'b0;
    end else begin
      pipe_vld_q <= (state_q == S_DOT);
    end
  end

  always_ff @(posedge clk_i) begin
    sel_q <= col_q[0];
    dot_q <= dot_d;
  end

  // int group sum to fp32, exact for sums up to 24 bits, rounded to nearest even above
  function automatic logic [31:0] int2f(input logic signed [DW-1:0] v);
    logic [31:0] mag, nrm;
    logic [4:0]  lz;
    logic        inc;
    logic [30:0] pk;
    mag = v[DW-1] ? 32'(-v) : 32'(v);
    lz = 5'd0;
    for (int i = 0; i < 32; i++) begin
      if (mag[i]) lz = 5'(31 - i);
    end
    nrm = mag << lz;
    inc = nrm[7] & ((|nrm[6:0]) | nrm[8]);
    pk = {8'(8'd158 - 8'(lz)), nrm[30:8]} + {30'd0, inc};
    if (mag == 32'd0) return 32'd0;
    return {v[DW-1], pk};
  endfunction

  // half to fp32, exact; nan payload moves to the upper mantissa
  function automatic logic [31:0] h2f(input logic [15:0] h);
    logic [4:0] ex;
    logic [9:0] man;
    logic [3:0] p;
    logic [9:0] mn;
    ex = h[14:10];
    man = h[9:0];
    p = 4'd0;
    for (int i = 0; i < 10; i++) begin
      if (man[i]) p = 4'(i);
    end
    mn = man << (4'd10 - p);
    if (ex == 5'h1F) return {h[15], 8'hFF, man, 13'd0};
    if (ex != 5'd0) return {h[15], 8'(ex) + 8'd112, man, 13'd0};
    if (man == 10'd0) return {h[15], 31'd0};
    return {h[15], 8'd103 + 8'(p), mn, 13'd0};
  endfunction

  // shared fp32 unit
  fpu_op_e     fpu_op;
  logic [31:0] fpu_a, fpu_b, fpu_res;
  logic [31:0] prod_q, acc_q;

  always_comb begin
    fpu_op = FPU_MUL;
    fpu_a  = acc_q;
    fpu_b  = ascale_q;
    if (state_q == S_MUL) begin
      fpu_a = int2f(dot_q);
      fpu_b = h2f(s_rd_q);
    end else if (state_q == S_ADD) begin
      fpu_op = FPU_ADD;
      fpu_b  = prod_q;
    end
  end

  gimv_fpu u_fpu (
    .op_i  (fpu_op),
    .a_i   (fpu_a),
    .b_i   (fpu_b),
    .res_o (fpu_res)
  );

  // output register
  logic        out_valid_q;
  logic [7:0]  res_row_q;
  logic [31:0] res_bits_q;
  assign out_valid_o   = out_valid_q;
  assign result_row_o  = res_row_q;
  assign result_bits_o = res_bits_q;

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc && (op_e'(operation_i) == OP_RUN) && run_ok) state_d = S_GRP;
      end
      S_GRP: begin
        // done once past the last column or the scale store runs out
        if ((gstart_q >= CW2'(cols_q)) || (int'(g_q) >= MAX_GROUPS)) state_d = S_FIN;
        else state_d = S_DOT;
      end
      S_DOT: begin
        if (col_q + CW2'(1) == gend_q) state_d = S_DRAIN;
      end
      S_DRAIN: state_d = S_MUL;
      S_MUL:   state_d = S_ADD;
      S_ADD:   state_d = S_GRP;
      S_FIN: begin
        if (!out_valid_q) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_FIN && !out_valid_q) out_valid_q <= 1'b1;
      else if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        run_row_q <= row_index_i;
        ascale_q  <= activation_scale_i;
        gstart_q  <= '0;
        g_q       <= '0;
        acc_q     <= 32'd0;
      end
      S_GRP: begin
        gend_q <= gend_new;
        col_q  <= gstart_q;
      end
      S_DOT: col_q <= col_q + CW2'(1);
      S_MUL: prod_q <= fpu_res;
      S_ADD: begin
        acc_q    <= fpu_res;
        gstart_q <= gend_q;
        g_q      <= g_q + GW'(1);
      end
      S_FIN: begin
        if (!out_valid_q) begin
          res_row_q  <= run_row_q;
          res_bits_q <= fpu_res;
        end
      end
      default: ;
    endcase
  end

  // checks
  `GIMV_ASSERT_IMP(a_res_from_fin, $rose(out_valid_o), $past(state_q == S_FIN))
  `GIMV_ASSERT_IMP(a_col_in_group, state_q == S_DOT, col_q < gend_q)
  `GIMV_ASSERT_IMP(a_mac_after_read, pipe_vld_q, $past(state_q == S_DOT))
  `GIMV_ASSERT_NXT(a_run_starts,
                   in_acc && (operation_i == OP_RUN) && run_ok, state_q == S_GRP)

endmodule

### test/matvec_row_checker.sv
module matvec_row_checker
  import gimv_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  logic [1:0]        operation_i,
  input  logic [7:0]        row_index_i,
  input  logic [9:0]        column_index_i,
  input  logic [7:0]        weight_byte_i,
  input  logic [15:0]       group_scale_half_i,
  input  logic signed [7:0] activation_value_i,
  input  logic [31:0]       activation_scale_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  logic [7:0]        result_row_i,
  input  logic [31:0]       result_bits_i,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_index_i,
  input  logic [10:0]       cfg_data_i,
  output int                fail_count_o,
  output int                pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0]  row;
    logic [31:0] bits;
  } row_result_t;

  logic [3:0]        weight_nib [0:262143];
  logic [15:0]       grp_scale  [0:16383];
  logic signed [7:0] act_val    [0:1023];
  int unsigned       rows_raw, cols_raw, gs_raw;
  row_result_t       row_results_q[$];
  int                mismatches;

  function automatic int unsigned clamp(int unsigned v, int unsigned lo, int unsigned hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic bit is_nan(logic [31:0] b);
    return b[30:23] == 8'hFF && b[22:0] != 0;
  endfunction

  function automatic bit is_inf(logic [31:0] b);
    return b[30:23] == 8'hFF && b[22:0] == 0;
  endfunction

  function automatic bit is_zero(logic [31:0] b);
    return b[30:0] == 0;
  endfunction

  // exact widening of a single into a double (nan handled by callers)
  function automatic real f32_to_real(logic [31:0] b);
    logic [63:0] d;
    logic [10:0] de;
    real         mag;
    if (b[30:23] == 0) begin
      if (b[22:0] == 0) begin
        d = {b[31], 63'b0};
      end else begin
        mag = real'(b[22:0]) * (2.0 ** (-149));
        d = $realtobits(mag);
        d[63] = b[31];
      end
    end else if (b[30:23] == 8'hFF) begin
      d = {b[31], 11'h7FF, 52'b0};
    end else begin
      de = {3'b0, b[30:23]} + 11'd896;
      d = {b[31], de, b[22:0], 29'b0};
    end
    return $bitstoreal(d);
  endfunction

  // round to nearest even into single, with subnormals and overflow
  function automatic logic [31:0] real_to_f32(real x);
    logic [63:0] d;
    logic [55:0] m, q, rem, hlf;
    int          e, sh;
    d = $realtobits(x);
    if (d[62:52] == 0) return {d[63], 31'b0};
    if (d[62:52] == 11'h7FF) return {d[63], 8'hFF, 23'b0};
    e = int'(d[62:52]) - 1023;
    m = {3'b0, 1'b1, d[51:0]};
    sh = (e >= -126) ? 29 : 29 + (-126 - e);
    if (sh > 54) return {d[63], 31'b0};
    q = m >> sh;
    rem = m & ((56'd1 << sh) - 56'd1);
    hlf = 56'd1 << (sh - 1);
    if (rem > hlf || (rem == hlf && q[0])) q = q + 56'd1;
    if (e >= -126) begin
      if (q[24]) begin
        q = q >> 1;
        e++;
      end
      if (e > 127) return {d[63], 8'hFF, 23'b0};
      return {d[63], 8'(e + 127), q[22:0]};
    end
    return {d[63], q[30:0]};
  endfunction

  // nan rule: first nan operand quieted, invalid gives the default nan
  function automatic logic [31:0] fp_mul(logic [31:0] a, logic [31:0] b);
    if (is_nan(a)) return a | FpQuietBit;
    if (is_nan(b)) return b | FpQuietBit;
    if ((is_inf(a) && is_zero(b)) || (is_zero(a) && is_inf(b))) return FpDefaultNan;
    return real_to_f32(f32_to_real(a) * f32_to_real(b));
  endfunction

  function automatic logic [31:0] fp_add(logic [31:0] a, logic [31:0] b);
    if (is_nan(a)) return a | FpQuietBit;
    if (is_nan(b)) return b | FpQuietBit;
    if (is_inf(a) && is_inf(b) && a[31] != b[31]) return FpDefaultNan;
    return real_to_f32(f32_to_real(a) + f32_to_real(b));
  endfunction

  function automatic logic [31:0] half_to_f32(logic [15:0] h);
    logic [9:0]  man;
    logic [10:0] nm;
    logic [7:0]  e;
    if (h[14:10] == 5'h1F) return {h[15], 8'hFF, h[9:0], 13'b0};
    if (h[14:10] != 0) return {h[15], 8'(h[14:10]) + 8'd112, h[9:0], 13'b0};
    if (h[9:0] == 0) return {h[15], 31'b0};
    // subnormal half becomes a normal single
    nm = {1'b0, h[9:0]};
    e = 8'd113;
    while (!nm[10]) begin
      nm = nm << 1;
      e = e - 8'd1;
    end
    man = nm[9:0];
    return {h[15], e, man, 13'b0};
  endfunction

  function automatic logic [31:0] row_product_bits(int unsigned row, logic [31:0] ascale);
    int unsigned cols, gs, stop, g;
    int          dot;
    logic [31:0] acc;
    cols = clamp(cols_raw, 1, 1024);
    gs = clamp(gs_raw, 16, 1024);
    acc = 32'h0;
    g = 0;
    for (int unsigned start = 0; start < cols; start += gs) begin
      stop = (start + gs > cols) ? cols : start + gs;
      if (g < 64) begin
        dot = 0;
        for (int unsigned c = start; c < stop; c++)
          dot += (int'(weight_nib[row * 1024 + c]) - 8) * int'(act_val[c]);
        acc = fp_add(acc, fp_mul(real_to_f32(real'(dot)),
                                 half_to_f32(grp_scale[row * 64 + g])));
      end
      g++;
    end
    return fp_mul(acc, ascale);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    row_result_t want;
    int unsigned c0;
    if (!rst_ni) begin
      rows_raw = 256;
      cols_raw = 1024;
      gs_raw = 32;
      row_results_q.delete();
      fail_count_o = 0;
      pending_o = 0;
      mismatches = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (row_results_q.size() == 0) begin
          fail_count_o++;
          if (mismatches++ < 10)
            $display("unexpected result: row %0d bits %h", result_row_i, result_bits_i);
        end else begin
          want = row_results_q.pop_front();
          if (want.row != result_row_i || want.bits != result_bits_i) begin
            fail_count_o++;
            if (mismatches++ < 10)
              $display("mismatch: row exp %0d got %0d, bits exp %h got %h",
                       want.row, result_row_i, want.bits, result_bits_i);
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        case (op_e'(operation_i))
          OP_LOAD_W: begin
            c0 = column_index_i * 2;
            if (c0 < 1024) weight_nib[row_index_i * 1024 + c0] = weight_byte_i[3:0];
            if (c0 + 1 < 1024) weight_nib[row_index_i * 1024 + c0 + 1] = weight_byte_i[7:4];
          end
          OP_LOAD_S: begin
            if (column_index_i < 64) grp_scale[row_index_i * 64 + column_index_i] = group_scale_half_i;
          end
          OP_LOAD_ACT: act_val[column_index_i] = activation_value_i;
          OP_RUN: begin
            if (row_index_i < clamp(rows_raw, 1, 256)) begin
              want.row = row_index_i;
              want.bits = row_product_bits(row_index_i, activation_scale_i);
              row_results_q.push_back(want);
            end
          end
          default: ;
        endcase
      end
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_ROWS: rows_raw = cfg_data_i[8:0];
          CFG_COLS: cols_raw = cfg_data_i;
          CFG_GS:   gs_raw = cfg_data_i;
          default: ;
        endcase
      end
      pending_o = row_results_q.size();
    end
  end

endmodule

### test/tb_grouped_int4_matvec_row.sv
module tb_grouped_int4_matvec_row
  import gimv_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int         CyclesLimit = 4_000_000;
  // index past the register list, the block ignores it
  localparam logic [1:0] CfgSpare = 2'd3;

  logic              clk_i, rst_ni;
  logic              in_valid, in_stall;
  logic [1:0]        operation;
  logic [7:0]        row_index;
  logic [9:0]        column_index;
  logic [7:0]        weight_byte;
  logic [15:0]       group_scale_half;
  logic signed [7:0] activation_value;
  logic [31:0]       activation_scale;
  logic              out_valid, out_stall;
  logic [7:0]        result_row;
  logic [31:0]       result_bits;
  logic              cfg_we;
  logic [1:0]        cfg_index;
  logic [10:0]       cfg_data;
  int                fail_count, pending;

  // stimulus-side view of the config and of what the stores hold
  int unsigned eff_rows, eff_cols, eff_gs;
  bit          w_done [0:262143];
  bit          s_done [0:16383];
  bit          a_done [0:1023];
  int          send_pct, recv_pct;
  int          results_seen, hold_left, cycles;
  bit          hold_done;

  grouped_int4_matvec_row dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid),
    .in_stall_o         (in_stall),
    .operation_i        (operation),
    .row_index_i        (row_index),
    .column_index_i     (column_index),
    .weight_byte_i      (weight_byte),
    .group_scale_half_i (group_scale_half),
    .activation_value_i (activation_value),
    .activation_scale_i (activation_scale),
    .out_valid_o        (out_valid),
    .out_stall_i        (out_stall),
    .result_row_o       (result_row),
    .result_bits_o      (result_bits),
    .cfg_we_i           (cfg_we),
    .cfg_index_i        (cfg_index),
    .cfg_data_i         (cfg_data)
  );

  matvec_row_checker u_checker (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid),
    .in_stall_i         (in_stall),
    .operation_i        (operation),
    .row_index_i        (row_index),
    .column_index_i     (column_index),
    .weight_byte_i      (weight_byte),
    .group_scale_half_i (group_scale_half),
    .activation_value_i (activation_value),
    .activation_scale_i (activation_scale),
    .out_valid_i        (out_valid),
    .out_stall_i        (out_stall),
    .result_row_i       (result_row),
    .result_bits_i      (result_bits),
    .cfg_we_i           (cfg_we),
    .cfg_index_i        (cfg_index),
    .cfg_data_i         (cfg_data),
    .fail_count_o       (fail_count),
    .pending_o          (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // watchdog on the whole run
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CyclesLimit) begin
      $display("grouped_int4_matvec_row test failed");
      $finish;
    end
  end

  always @(posedge clk_i)
    if (rst_ni && out_valid && !out_stall) results_seen++;

  // receiver: random stalls, plus one long hold-off once a few results came back
  // so the block fills up and stalls its input while the sender keeps offering
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (!hold_done && results_seen >= 4) begin
      hold_done = 1'b1;
      hold_left = 400;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_pct);
    end
  end

  // groups of the current config, capped at the scale store depth
  function automatic int unsigned num_groups();
    int unsigned g;
    g = (eff_cols + eff_gs - 1) / eff_gs;
    return (g > 64) ? 64 : g;
  endfunction

  // mostly moderate scales, now and then any half at all
  function automatic logic [15:0] rand_half();
    if ($urandom_range(9) == 0) return 16'($urandom);
    return {1'($urandom), 5'($urandom_range(18, 10)), 10'($urandom)};
  endfunction

  function automatic logic [31:0] rand_act_scale();
    case ($urandom_range(9))
      0: return $urandom;
      1: begin
        case ($urandom_range(6))
          0: return 32'h0000_0000;
          1: return 32'h8000_0000;
          2: return 32'h7F80_0000;
          3: return 32'h7FC0_0001;
          4: return 32'hFF80_0001;
          5: return 32'h0000_0001;
          default: return 32'h7F7F_FFFF;
        endcase
      end
      default: return {1'($urandom), 8'($urandom_range(130, 100)), 23'($urandom)};
    endcase
  endfunction

  // one transaction on the input channel, with random idle cycles first
  task automatic send_txn(op_e op, logic [7:0] row, logic [9:0] col, logic [7:0] wb,
                          logic [15:0] sh, logic [7:0] av, logic [31:0] as);
    int unsigned c0;
    while ($urandom_range(99) < send_pct) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    operation <= op;
    row_index <= row;
    column_index <= col;
    weight_byte <= wb;
    group_scale_half <= sh;
    activation_value <= av;
    activation_scale <= as;
    in_valid <= 1'b1;
    do @(posedge clk_i); while (in_stall);
    case (op)
      OP_LOAD_W: begin
        c0 = col * 2;
        if (c0 < 1024) w_done[row * 1024 + c0] = 1'b1;
        if (c0 + 1 < 1024) w_done[row * 1024 + c0 + 1] = 1'b1;
      end
      OP_LOAD_S: if (col < 64) s_done[row * 64 + col] = 1'b1;
      OP_LOAD_ACT: a_done[col] = 1'b1;
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  task automatic load_weight(logic [7:0] row, logic [9:0] col, logic [7:0] wb);
    send_txn(OP_LOAD_W, row, col, wb, 16'($urandom), 8'($urandom), $urandom);
  endtask

  task automatic load_scale(logic [7:0] row, logic [9:0] col, logic [15:0] sh);
    send_txn(OP_LOAD_S, row, col, 8'($urandom), sh, 8'($urandom), $urandom);
  endtask

  task automatic load_act(logic [9:0] col, logic [7:0] av);
    send_txn(OP_LOAD_ACT, 8'($urandom), col, 8'($urandom), 16'($urandom), av, $urandom);
  endtask

  // a run only goes out once every entry it reads has been written
  task automatic run_row(logic [7:0] row, logic [31:0] as);
    if (row < eff_rows) begin
      for (int unsigned c = 0; c < eff_cols; c += 2)
        if (!w_done[row * 1024 + c] || (c + 1 < eff_cols && !w_done[row * 1024 + c + 1]))
          load_weight(row, 10'(c / 2), 8'($urandom));
      for (int unsigned g = 0; g < num_groups(); g++)
        if (!s_done[row * 64 + g]) load_scale(row, 10'(g), rand_half());
      for (int unsigned c = 0; c < eff_cols; c++)
        if (!a_done[c]) load_act(10'(c), 8'($urandom));
    end
    send_txn(OP_RUN, row, 10'($urandom), 8'($urandom), 16'($urandom), 8'($urandom), as);
  endtask

  task automatic set_cfg(logic [1:0] idx, logic [10:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    @(negedge clk_i);
    case (cfg_idx_e'(idx))
      CFG_ROWS: eff_rows = (val[8:0] == 0) ? 1 : ((val[8:0] > 256) ? 256 : val[8:0]);
      CFG_COLS: eff_cols = (val == 0) ? 1 : ((val > 1024) ? 1024 : val);
      CFG_GS:   eff_gs = (val < 16) ? 16 : ((val > 1024) ? 1024 : val);
      default: ;
    endcase
  endtask

  // drain: wait for all results back, then idle before the next section
  task automatic settle();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (eff_cols + 4 * num_groups() + 16) @(negedge clk_i);
  endtask

  task automatic random_items(int n);
    int k;
    int unsigned run_rows;
    // runs stay on a few rows so the preloads stay short
    run_rows = (eff_rows < 4) ? eff_rows : 4;
    repeat (n) begin
      k = $urandom_range(99);
      if (k < 40) begin
        if ($urandom_range(9) < 8) run_row(8'($urandom_range(run_rows - 1)), rand_act_scale());
        else run_row(8'($urandom_range(255, 200)), rand_act_scale());
      end else if (k < 60) begin
        load_weight(8'($urandom_range(eff_rows - 1)),
                    ($urandom_range(9) == 0) ? 10'($urandom) : 10'($urandom_range(511)),
                    8'($urandom));
      end else if (k < 75) begin
        load_scale(8'($urandom_range(eff_rows - 1)),
                   ($urandom_range(9) == 0) ? 10'($urandom) : 10'($urandom_range(63)),
                   rand_half());
      end else begin
        load_act(($urandom_range(4) == 0) ? 10'($urandom) : 10'($urandom_range(eff_cols - 1)),
                 8'($urandom));
      end
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid = 1'b0;
    operation = '0;
    row_index = '0;
    column_index = '0;
    weight_byte = '0;
    group_scale_half = '0;
    activation_value = '0;
    activation_scale = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    eff_rows = 256;
    eff_cols = 1024;
    eff_gs = 32;
    send_pct = 17;
    recv_pct = 50;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // small matrix, three groups with the last one clipped
    set_cfg(CFG_ROWS, 11'd4);
    set_cfg(CFG_COLS, 11'd40);
    set_cfg(CFG_GS, 11'd16);
    set_cfg(CfgSpare, 11'h7FF);

    // directed: nibble extremes, scale specials, activation extremes
    load_weight(8'd0, 10'd0, 8'h00);
    load_weight(8'd0, 10'd1, 8'hFF);
    load_weight(8'd0, 10'd2, 8'h0F);
    load_weight(8'd0, 10'd3, 8'hF0);
    load_weight(8'd255, 10'd511, 8'hA5);
    load_weight(8'd1, 10'd1023, 8'h5A);    // both columns past the store
    load_scale(8'd0, 10'd0, 16'h3C00);
    load_scale(8'd0, 10'd1, 16'h0001);     // subnormal half
    load_scale(8'd0, 10'd2, 16'h7BFF);
    load_scale(8'd255, 10'd63, 16'hFFFF);
    load_scale(8'd0, 10'd1023, 16'h1234);  // group past the store
    load_act(10'd0, 8'sh80);
    load_act(10'd1, 8'sh7F);
    load_act(10'd1023, 8'sh00);
    run_row(8'd0, 32'h3F80_0000);
    run_row(8'd0, 32'h0000_0000);
    run_row(8'd0, 32'h7F80_0000);
    run_row(8'd0, 32'h7FC0_0001);
    run_row(8'd0, 32'h0000_0001);
    run_row(8'd3, 32'hBF80_0000);
    run_row(8'd4, 32'h3F80_0000);          // row beyond rows in use
    run_row(8'd255, 32'h3F80_0000);
    load_scale(8'd1, 10'd0, 16'h7C00);     // infinite scale
    run_row(8'd1, 32'h3F80_0000);
    load_scale(8'd1, 10'd0, 16'h7E01);     // nan scale with payload
    run_row(8'd1, 32'h3F80_0000);
    load_scale(8'd1, 10'd0, 16'h8000);
    run_row(8'd1, 32'h4000_0000);
    random_items(80);
    settle();

    // zero writes saturate to the low ends
    set_cfg(CFG_ROWS, 11'd0);
    set_cfg(CFG_COLS, 11'd0);
    set_cfg(CFG_GS, 11'd0);
    random_items(30);
    settle();

    send_pct = 50;
    recv_pct = 17;
    // all-ones writes saturate rows and group size to the high ends; 17 columns make a single group
    set_cfg(CFG_ROWS, 11'h1FF);
    set_cfg(CFG_COLS, 11'd17);
    set_cfg(CFG_GS, 11'h7FF);
    random_items(50);
    settle();

    // wider row over several full groups
    set_cfg(CFG_ROWS, 11'd256);
    set_cfg(CFG_COLS, 11'd64);
    set_cfg(CFG_GS, 11'd16);
    run_row(8'd0, 32'h3F80_0000);
    run_row(8'd0, rand_act_scale());
    run_row(8'd0, rand_act_scale());
    settle();

    send_pct = 0;
    recv_pct = 0;
    set_cfg(CFG_ROWS, 11'd200);
    set_cfg(CFG_COLS, 11'd100);
    set_cfg(CFG_GS, 11'd33);
    random_items(60);
    settle();

    if (fail_count == 0) begin
      $display("grouped_int4_matvec_row test passed");
    end else begin
      $display("grouped_int4_matvec_row test failed");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+hdl
hdl/gimv_pkg.sv
hdl/gimv_fpu.sv
hdl/grouped_int4_matvec_row.sv
test/matvec_row_checker.sv
test/tb_grouped_int4_matvec_row.sv
